// File: hdl/cda_pkg.sv
// types, opcodes and calendar helpers shared by the calendar date adder
package cda_pkg;

	localparam logic [1:0] OP_LOAD       = 2'd0;
	localparam logic [1:0] OP_ADD_DAYS   = 2'd1;
	localparam logic [1:0] OP_ADD_MONTHS = 2'd2;
	localparam logic [1:0] OP_ADD_YEARS  = 2'd3;

	localparam int RESET_YEAR = 2021;

	// rounded-up reciprocals: x/12 = (x*RECIP_BY12) >> 27 for x below 2^25,
	// x/25 = (x*RECIP_BY25) >> 32 for x below 2^28
	localparam logic [27:0] RECIP_BY12 = 28'd11184811;
	localparam logic [27:0] RECIP_BY25 = 28'd171798692;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] load_year;
		logic [3:0]  load_month;
		logic [4:0]  load_day;
		logic [15:0] amount;
	} req_t;

	typedef struct packed {
		logic [15:0] cur_year;
		logic [3:0]  cur_month;
		logic [4:0]  cur_day;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic mod400;
	} div_ctl_t;

	// leap test from the year's remainder modulo 400
	function automatic logic is_leap(input logic [8:0] r);
		logic century;
		century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
		return (r[1:0] == 2'b00) && !century;
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage

// File: hdl/calendar_date_adder_unit.sv
// calendar date adder: date registers, sequencer and month-stepping day loop
// load and add years go straight from idle to the output state; add months passes the divider first,
// add days passes the divider and then the day loop
// the day loop steps one month per cycle
// one item at a time: the next beat is taken once the previous result has moved to the output register
// reset: date goes to 2021-01-01, sequencer idle, no output beat pending
module calendar_date_adder_unit #(
	parameter int YEAR_BITS   = 16,
	parameter int AMOUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cda_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cda_pkg::rsp_t rsp
);

	localparam int RW = AMOUNT_BITS + 1;
	localparam int DW = (YEAR_BITS > AMOUNT_BITS) ? YEAR_BITS : AMOUNT_BITS + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DAYS = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]           state_q;
	logic [1:0]           op_q;
	logic [YEAR_BITS-1:0] year_q;
	logic [3:0]           month_q;
	logic [4:0]           day_q;
	logic [RW-1:0]        rem_q;
	logic [8:0]           r400_q;
	cda_pkg::rsp_t        rsp_q;
	logic                 rsp_valid_q;

	logic                           accept;
	logic [YEAR_BITS+15:0]          ly_ext;
	logic [AMOUNT_BITS+15:0]        amt_ext;
	logic [AMOUNT_BITS-1:0]         amt;
	logic [YEAR_BITS+AMOUNT_BITS-1:0] yadd;
	logic [3:0]                     ld_month;
	logic [4:0]                     ld_day;
	logic [3:0]                     m0;
	logic [RW-1:0]                  tot;
	logic [DW+RW-1:0]               tot_ext;
	logic [DW+YEAR_BITS-1:0]        yr_ext;
	logic [YEAR_BITS+15:0]          yr_out;
	cda_pkg::div_ctl_t              div_ctl;
	logic [DW-1:0]                  dividend;
	logic                           div_done;
	logic [DW-1:0]                  quot;
	logic [8:0]                     drem;
	logic                           leap;
	logic [4:0]                     len;
	logic [RW:0]                    sum;
	logic [RW:0]                    len_ext;
	logic                           fits;
	logic [RW:0]                    rem_nx;
	logic                           out_free;

	assign accept   = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign out_free = !rsp_valid_q || rsp_ready;

	assign ly_ext  = {{YEAR_BITS{1'b0}}, req.load_year};
	assign amt_ext = {{AMOUNT_BITS{1'b0}}, req.amount};
	assign amt     = amt_ext[AMOUNT_BITS-1:0];
	assign yadd    = {{AMOUNT_BITS{1'b0}}, year_q} + {{YEAR_BITS{1'b0}}, amt};

	always_comb begin
		ld_month = req.load_month;
		if (ld_month == 4'd0) begin
			ld_month = 4'd1;
		end else if (ld_month > 4'd12) begin
			ld_month = 4'd12;
		end
		ld_day = (req.load_day == 5'd0) ? 5'd1 : req.load_day;
	end

	// months op: (month-1)+amount, divided by 12
	assign m0      = month_q - 4'd1;
	assign tot     = {1'b0, amt} + {{(RW-4){1'b0}}, m0};
	assign tot_ext = {{DW{1'b0}}, tot};
	assign yr_ext  = {{DW{1'b0}}, year_q};

	assign div_ctl.start  = accept && ((req.opcode == cda_pkg::OP_ADD_MONTHS) ||
		(req.opcode == cda_pkg::OP_ADD_DAYS));
	assign div_ctl.mod400 = (req.opcode == cda_pkg::OP_ADD_DAYS);
	assign dividend = (req.opcode == cda_pkg::OP_ADD_DAYS) ? yr_ext[DW-1:0] : tot_ext[DW-1:0];

	cda_div_unit #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dividend),
		.done     (div_done),
		.quotient (quot),
		.remainder(drem)
	);

	// day loop: one month per cycle
	assign leap    = cda_pkg::is_leap(r400_q);
	assign len     = cda_pkg::days_in_month(month_q, leap);
	assign sum     = {1'b0, rem_q} + {{(RW-4){1'b0}}, day_q};
	assign len_ext = {{(RW-4){1'b0}}, len};
	assign fits    = sum <= len_ext;
	assign rem_nx  = sum - len_ext - {{RW{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= cda_pkg::OP_LOAD;
			year_q      <= YEAR_BITS'(cda_pkg::RESET_YEAR);
			month_q     <= 4'd1;
			day_q       <= 5'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= req.opcode;
						case (req.opcode)
							cda_pkg::OP_LOAD: begin
								year_q  <= ly_ext[YEAR_BITS-1:0];
								month_q <= ld_month;
								day_q   <= ld_day;
								state_q <= ST_OUT;
							end
							cda_pkg::OP_ADD_YEARS: begin
								year_q  <= yadd[YEAR_BITS-1:0];
								state_q <= ST_OUT;
							end
							default: begin
								state_q <= ST_DIV;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (op_q == cda_pkg::OP_ADD_MONTHS) begin
							year_q  <= year_q + quot[YEAR_BITS-1:0];
							month_q <= drem[3:0] + 4'd1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_DAYS;
						end
					end
				end
				ST_DAYS: begin
					if (fits) begin
						day_q   <= sum[4:0];
						state_q <= ST_OUT;
					end else begin
						day_q <= 5'd1;
						if (month_q == 4'd12) begin
							month_q <= 4'd1;
							year_q  <= year_q + YEAR_BITS'(1);
						end else begin
							month_q <= month_q + 4'd1;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// day count and year remainder modulo 400 for the day loop
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= {1'b0, amt};
		end else if (state_q == ST_DAYS && !fits) begin
			rem_q <= rem_nx[RW-1:0];
		end
		if (state_q == ST_DIV && div_done) begin
			r400_q <= drem;
		end else if (state_q == ST_DAYS && !fits && month_q == 4'd12) begin
			if ((&year_q) || (r400_q == 9'd399)) begin
				r400_q <= '0;
			end else begin
				r400_q <= r400_q + 9'd1;
			end
		end
	end

	assign yr_out = {16'd0, year_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			rsp_q.cur_year  <= yr_out[15:0];
			rsp_q.cur_month <= month_q;
			rsp_q.cur_day   <= day_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(month_q != 4'd0) && (month_q <= 4'd12))
		else $error("month register out of range");

	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		day_q != 5'd0)
		else $error("day register is zero");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_cycle_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DAYS) |-> (r400_q < 9'd400))
		else $error("year remainder out of range in day loop");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (rsp_valid_q && rsp_q.cur_day == day_q))
		else $error("result beat not loaded from date registers");
`endif

endmodule

// File: hdl/cda_div_unit.sv
// shared reciprocal-multiply divider by 12 or by 400; the start flag is registered in mul_q and then done_q
module cda_div_unit #(
	parameter int DW = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cda_pkg::div_ctl_t ctl,
	input  logic [DW-1:0]     dividend,
	output logic              done,
	output logic [DW-1:0]     quotient,
	output logic [8:0]        remainder
);

	logic [31:0] num_q;
	logic        mod400_q;
	logic        mul_q;
	logic        done_q;
	logic [23:0] quo_q;

	logic [55:0] mul_a;
	logic [55:0] mul_b;
	logic [55:0] prod;
	logic [23:0] quo;
	logic [8:0]  q9;
	logic [8:0]  qd9;
	logic [31:0] quo_ext;

	// x/400 taken as (x/16)/25
	assign mul_a = mod400_q ? {28'd0, num_q[31:4]} : {31'd0, num_q[24:0]};
	assign mul_b = {28'd0, (mod400_q ? cda_pkg::RECIP_BY25 : cda_pkg::RECIP_BY12)};
	assign prod  = mul_a * mul_b;
	assign quo   = mod400_q ? prod[55:32] : prod[50:27];

	// remainder is below 400, so nine bits of quotient times divisor suffice
	assign q9  = quo_q[8:0];
	assign qd9 = mod400_q ? ({q9[0], 8'd0} + {q9[1:0], 7'd0} + {q9[4:0], 4'd0}) :
		({q9[5:0], 3'd0} + {q9[6:0], 2'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= ctl.start;
			done_q <= mul_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q    <= 32'(dividend);
			mod400_q <= ctl.mod400;
		end
		if (mul_q) begin
			quo_q <= quo;
		end
	end

	assign quo_ext   = {8'd0, quo_q};
	assign done      = done_q;
	assign quotient  = quo_ext[DW-1:0];
	assign remainder = num_q[8:0] - qd9;

endmodule

// File: verif/calendar_date_adder_unit_tb.sv
// testbench for calendar_date_adder_unit: directed table and random date ops checked per beat
`timescale 1ns / 100ps

module calendar_date_adder_unit_tb;

	localparam int CYCLE_LIMIT = 5000000;
	localparam int N_DIRECTED  = 22;
	localparam int N_PER_PHASE = 83;

	typedef struct {
		cda_pkg::req_t item;
		bit            typed;
		cda_pkg::rsp_t want;
	} date_case_t;

	bit            clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	cda_pkg::req_t req;
	logic          rsp_valid;
	bit            rsp_ready;
	cda_pkg::rsp_t rsp;

	logic [15:0] model_year;
	logic [3:0]  model_month;
	logic [4:0]  model_day;

	cda_pkg::rsp_t expected_dates[$];
	cda_pkg::rsp_t want_date;
	int   mismatches;
	int   cycle_count;
	int   req_idle_pct;
	int   rsp_idle_pct;
	int   phase;
	int   hold_left;
	bit   hold_done;

	date_case_t directed_dates [N_DIRECTED] = '{
		'{{cda_pkg::OP_ADD_DAYS, 16'd0, 4'd0, 5'd0, 16'd0}, 1'b1, {16'd2021, 4'd1, 5'd1}},
		'{{cda_pkg::OP_LOAD, 16'd0, 4'd0, 5'd0, 16'd0}, 1'b1, {16'd0, 4'd1, 5'd1}},
		'{{cda_pkg::OP_LOAD, 16'hFFFF, 4'd15, 5'd31, 16'd0}, 1'b1, {16'hFFFF, 4'd12, 5'd31}},
		'{{cda_pkg::OP_ADD_DAYS, 16'd0, 4'd0, 5'd0, 16'd1}, 1'b1, {16'd0, 4'd1, 5'd1}},
		'{{cda_pkg::OP_ADD_YEARS, 16'd0, 4'd0, 5'd0, 16'hFFFF}, 1'b1, {16'hFFFF, 4'd1, 5'd1}},
		'{{cda_pkg::OP_ADD_MONTHS, 16'd0, 4'd0, 5'd0, 16'd11}, 1'b1, {16'hFFFF, 4'd12, 5'd1}},
		'{{cda_pkg::OP_ADD_MONTHS, 16'd0, 4'd0, 5'd0, 16'd1}, 1'b1, {16'd0, 4'd1, 5'd1}},
		'{{cda_pkg::OP_LOAD, 16'd2023, 4'd2, 5'd31, 16'd0}, 1'b1, {16'd2023, 4'd2, 5'd31}},
		'{{cda_pkg::OP_ADD_DAYS, 16'd0, 4'd0, 5'd0, 16'd0}, 1'b1, {16'd2023, 4'd3, 5'd3}},
		'{{cda_pkg::OP_LOAD, 16'd2000, 4'd2, 5'd28, 16'd0}, 1'b1, {16'd2000, 4'd2, 5'd28}},
		'{{cda_pkg::OP_ADD_DAYS, 16'd0, 4'd0, 5'd0, 16'd1}, 1'b1, {16'd2000, 4'd2, 5'd29}},
		'{{cda_pkg::OP_LOAD, 16'd1900, 4'd2, 5'd28, 16'd0}, 1'b1, {16'd1900, 4'd2, 5'd28}},
		'{{cda_pkg::OP_ADD_DAYS, 16'd0, 4'd0, 5'd0, 16'd1}, 1'b1, {16'd1900, 4'd3, 5'd1}},
		'{{cda_pkg::OP_LOAD, 16'd2100, 4'd2, 5'd29, 16'd0}, 1'b1, {16'd2100, 4'd2, 5'd29}},
		'{{cda_pkg::OP_ADD_DAYS, 16'd0, 4'd0, 5'd0, 16'd0}, 1'b1, {16'd2100, 4'd3, 5'd1}},
		'{{cda_pkg::OP_LOAD, 16'd2024, 4'd1, 5'd31, 16'hFFFF}, 1'b1, {16'd2024, 4'd1, 5'd31}},
		'{{cda_pkg::OP_ADD_MONTHS, 16'hFFFF, 4'hF, 5'h1F, 16'd1}, 1'b0, {16'd0, 4'd0, 5'd0}},
		'{{cda_pkg::OP_ADD_DAYS, 16'hAAAA, 4'hA, 5'h15, 16'hFFFF}, 1'b0, {16'd0, 4'd0, 5'd0}},
		'{{cda_pkg::OP_ADD_MONTHS, 16'h5555, 4'h5, 5'h0A, 16'hFFFF}, 1'b0, {16'd0, 4'd0, 5'd0}},
		'{{cda_pkg::OP_ADD_YEARS, 16'd0, 4'd0, 5'd0, 16'd12345}, 1'b0, {16'd0, 4'd0, 5'd0}},
		'{{cda_pkg::OP_LOAD, 16'h5555, 4'd13, 5'd0, 16'h5555}, 1'b1, {16'h5555, 4'd12, 5'd1}},
		'{{cda_pkg::OP_ADD_DAYS, 16'd0, 4'd0, 5'd0, 16'hAAAA}, 1'b0, {16'd0, 4'd0, 5'd0}}
	};

	calendar_date_adder_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	function automatic bit leap_year(input logic [15:0] y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_days(input logic [15:0] y, input logic [3:0] m);
		case (m)
			4'd2: begin
				return leap_year(y) ? 29 : 28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	function automatic void advance_months(input int unsigned n);
		int unsigned total;
		total = {28'd0, model_month} - 32'd1 + n;
		model_year = model_year + 16'(total / 12);
		model_month = 4'(total % 12 + 1);
	endfunction

	function automatic cda_pkg::rsp_t step_calendar(input cda_pkg::req_t item);
		int unsigned rem;
		int unsigned d;
		int unsigned len;
		case (item.opcode)
			cda_pkg::OP_LOAD: begin
				model_year = item.load_year;
				model_month = (item.load_month == 4'd0) ? 4'd1 :
					(item.load_month > 4'd12) ? 4'd12 : item.load_month;
				model_day = (item.load_day == 5'd0) ? 5'd1 : item.load_day;
			end
			cda_pkg::OP_ADD_DAYS: begin
				rem = {16'd0, item.amount};
				d = {27'd0, model_day};
				len = month_days(model_year, model_month);
				while (d + rem > len) begin
					rem = rem + d - 1 - len;
					d = 1;
					advance_months(32'd1);
					len = month_days(model_year, model_month);
				end
				model_day = 5'(d + rem);
			end
			cda_pkg::OP_ADD_MONTHS: begin
				advance_months({16'd0, item.amount});
			end
			default: begin
				model_year = model_year + item.amount;
			end
		endcase
		return {model_year, model_month, model_day};
	endfunction

	function automatic cda_pkg::req_t random_date_op();
		cda_pkg::req_t r;
		int            pick;
		r.load_year = 16'($urandom);
		r.load_month = 4'($urandom);
		r.load_day = 5'($urandom);
		r.amount = 16'($urandom);
		pick = $urandom_range(99);
		r.opcode = (pick < 20) ? cda_pkg::OP_LOAD : (pick < 60) ? cda_pkg::OP_ADD_DAYS :
			(pick < 80) ? cda_pkg::OP_ADD_MONTHS : cda_pkg::OP_ADD_YEARS;
		pick = $urandom_range(99);
		if (r.opcode == cda_pkg::OP_ADD_DAYS) begin
			if (pick >= 60)
				r.amount = 16'($urandom_range(1500));
			else if (pick >= 8)
				r.amount = 16'($urandom_range(40));
		end else if (r.opcode == cda_pkg::OP_LOAD && pick < 70) begin
			r.load_month = 4'($urandom_range(12, 1));
			r.load_day = 5'($urandom_range(28, 1));
			if (pick < 35)
				r.load_year = 16'($urandom_range(2400, 1600));
			if (pick < 20)
				r.load_month = 4'd2;
		end
		return r;
	endfunction

	task automatic offer_beat(input cda_pkg::req_t item, input bit typed,
		input cda_pkg::rsp_t want);
		cda_pkg::rsp_t predicted;
		if ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < req_idle_pct)
				@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		predicted = step_calendar(item);
		expected_dates.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (phase == 2 && !hold_done) begin
			rsp_ready <= 1'b0;
			hold_left = 3000;
			hold_done = 1'b1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_dates.size() == 0) begin
				$error("unexpected beat: %0d-%0d-%0d", rsp.cur_year, rsp.cur_month, rsp.cur_day);
				mismatches++;
			end else begin
				want_date = expected_dates.pop_front();
				if (rsp.cur_year !== want_date.cur_year) begin
					$error("cur_year expected %0d actual %0d", want_date.cur_year, rsp.cur_year);
					mismatches++;
				end
				if (rsp.cur_month !== want_date.cur_month) begin
					$error("cur_month expected %0d actual %0d", want_date.cur_month, rsp.cur_month);
					mismatches++;
				end
				if (rsp.cur_day !== want_date.cur_day) begin
					$error("cur_day expected %0d actual %0d", want_date.cur_day, rsp.cur_day);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		phase = 0;
		req_idle_pct = 38;
		rsp_idle_pct = 70;
		model_year = 16'(cda_pkg::RESET_YEAR);
		model_month = 4'd1;
		model_day = 5'd1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			offer_beat(directed_dates[i].item, directed_dates[i].typed, directed_dates[i].want);
		for (int p = 0; p < 3; p++) begin
			phase = p;
			req_idle_pct = (p == 0) ? 38 : (p == 1) ? 70 : 0;
			rsp_idle_pct = (p == 0) ? 70 : (p == 1) ? 38 : 0;
			repeat (N_PER_PHASE)
				offer_beat(random_date_op(), 1'b0, '0);
		end
		req_valid <= 1'b0;
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
hdl/cda_pkg.sv
hdl/cda_div_unit.sv
hdl/calendar_date_adder_unit.sv
verif/calendar_date_adder_unit_tb.sv
